/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands. Clock and reset come from the using scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

/* sv/jsv_pkg.sv */
// ----------------------------------------------------------------------------
// jsv_pkg
// Types and constants shared by the JSON structure validator.
// ----------------------------------------------------------------------------
package jsv_pkg;

   localparam int MAX_DEPTH_DEFAULT = 512;
   localparam int DEPTH_W           = 9;
   localparam int LINE_W            = 20;
   localparam int TOKEN_W           = 4;
   localparam int STATUS_W          = 2;

   typedef enum logic [2:0] {
      PS_VALUE,
      PS_KEY_OR_CLOSE,
      PS_COLON,
      PS_OBJ_VALUE,
      PS_OBJ_NEXT,
      PS_ARR_VALUE,
      PS_ARR_NEXT
   } parse_state_type;

   typedef enum logic [1:0] {
      RET_DONE,
      RET_OBJ,
      RET_ARR
   } ret_type;

   typedef enum logic [TOKEN_W-1:0] {
      TOK_LBRACKET = 4'd0,
      TOK_RBRACKET = 4'd1,
      TOK_LBRACE   = 4'd2,
      TOK_RBRACE   = 4'd3,
      TOK_COLON    = 4'd4,
      TOK_COMMA    = 4'd5,
      TOK_STRING   = 4'd6,
      TOK_TRUE     = 4'd7,
      TOK_FALSE    = 4'd8,
      TOK_NULL     = 4'd9,
      TOK_NUMBER   = 4'd10,
      TOK_EOF      = 4'd11,
      TOK_OTHER    = 4'd12
   } token_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_BUSY,
      ST_COMPLETE,
      ST_FAIL
   } status_type;

   typedef struct packed {
      logic               new_document;
      logic [TOKEN_W-1:0] token_class;
      logic [LINE_W-1:0]  token_line;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] parse_status;
      logic [DEPTH_W-1:0]  nesting_depth;
      logic [LINE_W-1:0]   error_line;
   } rsp_type;

   typedef struct packed {
      logic    en;
      ret_type data;
   } stack_wr_type;

endpackage

/* sv/jsv_stack.sv */
// ----------------------------------------------------------------------------
// jsv_stack
// Return stack memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module jsv_stack #(
   parameter int MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEFAULT,
   localparam int CW = $clog2(MAX_DEPTH)
) (
   input  logic                  clock,
   input  jsv_pkg::stack_wr_type wr,
   input  logic [CW-1:0]         wr_addr,
   input  logic [CW-1:0]         rd_addr,
   output jsv_pkg::ret_type      rd_data
);

   jsv_pkg::ret_type mem [MAX_DEPTH];
   jsv_pkg::ret_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/jsv_engine.sv */
// ----------------------------------------------------------------------------
// jsv_engine
// Pushdown parse control: state, depth count, cached stack top, sticky status.
// ----------------------------------------------------------------------------
module jsv_engine #(
   parameter int MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEFAULT,
   localparam int CW = $clog2(MAX_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  jsv_pkg::req_type      req_data,
   input  logic                  require_end,
   input  jsv_pkg::ret_type      below_raw,
   output jsv_pkg::stack_wr_type stack_wr,
   output logic [CW-1:0]         wr_addr,
   output logic [CW-1:0]         rd_addr,
   output jsv_pkg::rsp_type      result
);

   jsv_pkg::parse_state_type state_ff, state_in, st, st_n;
   logic [CW-1:0]            count_ff, count_in, cnt, cnt_n;
   jsv_pkg::ret_type         top_ff, top_in, top, top_n, below;
   logic                     await_ff, await_in, aw, aw_n;
   jsv_pkg::status_type      status_ff, status_in, fs, fs_n;
   logic [jsv_pkg::LINE_W-1:0] eline_ff, eline_in, el, el_n;

   logic                     new_doc;
   logic [jsv_pkg::TOKEN_W-1:0] tc;
   logic                     scalar;
   logic                     do_close;
   logic                     do_open;
   logic                     do_fail;
   jsv_pkg::ret_type         open_ret;
   jsv_pkg::parse_state_type open_next;
   logic                     push_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= jsv_pkg::PS_VALUE;
         count_ff  <= CW'(1);
         top_ff    <= jsv_pkg::RET_DONE;
         await_ff  <= 1'b0;
         status_ff <= jsv_pkg::ST_BUSY;
         eline_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         top_ff    <= top_in;
         await_ff  <= await_in;
         status_ff <= status_in;
         eline_ff  <= eline_in;
      end
   end

   always_comb begin
      new_doc   = req_data.new_document;
      tc        = req_data.token_class;
      st        = new_doc ? jsv_pkg::PS_VALUE : state_ff;
      cnt       = new_doc ? CW'(1) : count_ff;
      top       = new_doc ? jsv_pkg::RET_DONE : top_ff;
      aw        = new_doc ? 1'b0 : await_ff;
      fs        = new_doc ? jsv_pkg::ST_BUSY : status_ff;
      el        = new_doc ? '0 : eline_ff;
      // entry zero is the fixed base entry and never lives in memory
      below     = (count_ff == CW'(2)) ? jsv_pkg::RET_DONE : below_raw;
      scalar    = (tc >= jsv_pkg::TOK_STRING) && (tc <= jsv_pkg::TOK_NUMBER);

      st_n      = st;
      cnt_n     = cnt;
      top_n     = top;
      aw_n      = aw;
      fs_n      = fs;
      el_n      = el;
      do_close  = 1'b0;
      do_open   = 1'b0;
      do_fail   = 1'b0;
      open_ret  = jsv_pkg::RET_OBJ;
      open_next = jsv_pkg::PS_ARR_VALUE;
      push_en   = 1'b0;

      if (fs == jsv_pkg::ST_BUSY) begin
         if (aw) begin
            if (tc == jsv_pkg::TOK_EOF) begin
               aw_n = 1'b0;
               fs_n = jsv_pkg::ST_COMPLETE;
            end else begin
               do_fail = 1'b1;
            end
         end else begin
            unique case (st)
               jsv_pkg::PS_VALUE: begin
                  if (tc == jsv_pkg::TOK_LBRACKET) st_n = jsv_pkg::PS_ARR_VALUE;
                  else if (tc == jsv_pkg::TOK_LBRACE) st_n = jsv_pkg::PS_KEY_OR_CLOSE;
                  else if (scalar) do_close = 1'b1;
                  else do_fail = 1'b1;
               end
               jsv_pkg::PS_KEY_OR_CLOSE: begin
                  if (tc == jsv_pkg::TOK_RBRACE) do_close = 1'b1;
                  else if (tc == jsv_pkg::TOK_STRING) st_n = jsv_pkg::PS_COLON;
                  else do_fail = 1'b1;
               end
               jsv_pkg::PS_COLON: begin
                  if (tc == jsv_pkg::TOK_COLON) st_n = jsv_pkg::PS_OBJ_VALUE;
                  else do_fail = 1'b1;
               end
               jsv_pkg::PS_OBJ_VALUE: begin
                  open_ret = jsv_pkg::RET_OBJ;
                  if (scalar) st_n = jsv_pkg::PS_OBJ_NEXT;
                  else if (tc == jsv_pkg::TOK_LBRACKET) begin
                     do_open   = 1'b1;
                     open_next = jsv_pkg::PS_ARR_VALUE;
                  end else if (tc == jsv_pkg::TOK_LBRACE) begin
                     do_open   = 1'b1;
                     open_next = jsv_pkg::PS_KEY_OR_CLOSE;
                  end else do_fail = 1'b1;
               end
               jsv_pkg::PS_OBJ_NEXT: begin
                  if (tc == jsv_pkg::TOK_COMMA) st_n = jsv_pkg::PS_KEY_OR_CLOSE;
                  else if (tc == jsv_pkg::TOK_RBRACE) do_close = 1'b1;
                  else do_fail = 1'b1;
               end
               jsv_pkg::PS_ARR_VALUE: begin
                  open_ret = jsv_pkg::RET_ARR;
                  if (tc == jsv_pkg::TOK_RBRACKET) do_close = 1'b1;
                  else if (scalar) st_n = jsv_pkg::PS_ARR_NEXT;
                  else if (tc == jsv_pkg::TOK_LBRACKET) begin
                     do_open   = 1'b1;
                     open_next = jsv_pkg::PS_ARR_VALUE;
                  end else if (tc == jsv_pkg::TOK_LBRACE) begin
                     do_open   = 1'b1;
                     open_next = jsv_pkg::PS_KEY_OR_CLOSE;
                  end else do_fail = 1'b1;
               end
               jsv_pkg::PS_ARR_NEXT: begin
                  if (tc == jsv_pkg::TOK_RBRACKET) do_close = 1'b1;
                  else if (tc == jsv_pkg::TOK_COMMA) st_n = jsv_pkg::PS_ARR_VALUE;
                  else do_fail = 1'b1;
               end
               default: do_fail = 1'b1;
            endcase
         end
      end

      if (do_close) begin
         if (top == jsv_pkg::RET_DONE) begin
            st_n  = jsv_pkg::PS_VALUE;
            cnt_n = '0;
            if (require_end) aw_n = 1'b1;
            else fs_n = jsv_pkg::ST_COMPLETE;
         end else begin
            st_n  = (top == jsv_pkg::RET_OBJ) ? jsv_pkg::PS_OBJ_NEXT : jsv_pkg::PS_ARR_NEXT;
            cnt_n = cnt - CW'(1);
            top_n = below;
         end
      end

      if (do_open) begin
         if (({1'b0, cnt} + (CW+1)'(1)) >= (CW+1)'(MAX_DEPTH)) begin
            do_fail = 1'b1;
         end else begin
            push_en = 1'b1;
            cnt_n   = cnt + CW'(1);
            top_n   = open_ret;
            st_n    = open_next;
         end
      end

      if (do_fail) begin
         fs_n = jsv_pkg::ST_FAIL;
         el_n = req_data.token_line;
      end

      state_in  = accept ? st_n  : state_ff;
      count_in  = accept ? cnt_n : count_ff;
      top_in    = accept ? top_n : top_ff;
      await_in  = accept ? aw_n  : await_ff;
      status_in = accept ? fs_n  : status_ff;
      eline_in  = accept ? el_n  : eline_ff;

      stack_wr.en   = accept && push_en;
      stack_wr.data = open_ret;
      wr_addr       = cnt;
      // prefetch the entry below the next top
      rd_addr       = count_in - CW'(2);

      result.parse_status  = fs_n;
      result.nesting_depth = (st_n == jsv_pkg::PS_VALUE) ? '0 : jsv_pkg::DEPTH_W'(cnt_n);
      result.error_line    = (fs_n == jsv_pkg::ST_FAIL) ? el_n : '0;
   end

endmodule

/* sv/json_structure_validator.sv */
// ----------------------------------------------------------------------------
// json_structure_validator
// Structure check of a JSON token stream with a pushdown automaton.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one token per transaction (new_document, token_class, token_line).
//   rsp_*  : one result per token (parse_status, nesting_depth, error_line).
//   csr_*  : writes require_end_of_input; always ready. Write only when idle.
// Throughput: one token per cycle, sustained. The stack top is held in a
//   register and the next lower entry is prefetched from the stack memory
//   every cycle, so pushes and pops back to back need no bubble.
// Result: registered, and shows in the cycle after the token is accepted.
// Stalls: req_ready is low only while a result is held and rsp_ready is
//   low; the held result stays stable until taken.
// Reset: reset starts an empty document and clears the setting. The stack
//   memory needs no clearing pass.
// Errors and completion are sticky until a token raises new_document.
// ----------------------------------------------------------------------------
module json_structure_validator #(
   parameter int MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsv_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata
);

   localparam int CW = $clog2(MAX_DEPTH);

   logic                  accept;
   logic                  req_end_ff, req_end_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   jsv_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   jsv_pkg::rsp_type      result;
   jsv_pkg::stack_wr_type stack_wr;
   jsv_pkg::ret_type      below_raw;
   logic [CW-1:0]         wr_addr;
   logic [CW-1:0]         rd_addr;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      req_end_in   = (csr_valid && csr_ready) ? csr_wdata : req_end_ff;
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = accept ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_end_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_end_ff   <= req_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   jsv_engine #(.MAX_DEPTH(MAX_DEPTH)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .require_end (req_end_ff),
      .below_raw   (below_raw),
      .stack_wr    (stack_wr),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .result      (result)
   );

   jsv_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
      .clock   (clock),
      .wr      (stack_wr),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .rd_data (below_raw)
   );

endmodule

/* sv/jsv_checker.sv */
// ----------------------------------------------------------------------------
// jsv_checker
// Port-level assertions for the JSON structure validator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsv_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input jsv_pkg::rsp_type rsp_data
);

   logic rsp_fail;
   logic rsp_done;

   assign rsp_fail = rsp_valid && (rsp_data.parse_status == jsv_pkg::ST_FAIL);
   assign rsp_done = rsp_valid && (rsp_data.parse_status == jsv_pkg::ST_COMPLETE);

   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ASSERT_NEXT(a_one_result, req_valid && req_ready, rsp_valid)
   `ASSERT_NOW(a_line_only_on_error, rsp_valid && !rsp_fail, rsp_data.error_line == '0)
   `ASSERT_NOW(a_done_depth_zero, rsp_done, rsp_data.nesting_depth == '0)
   `ASSERT_NOW(a_status_code, rsp_valid, rsp_data.parse_status <= jsv_pkg::ST_FAIL)

endmodule

bind json_structure_validator jsv_checker u_checker (.*);

/* dv/tb_json_structure_validator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_structure_validator
// Drives JSON token classes into the structure validator through a
// valid/ready driver and checks every result against a pushdown predictor
// kept in step with each accepted transaction. Directed documents cover
// every token class, nesting to the depth limit and the end-of-input
// check. Random documents follow, mostly well formed, some cut short,
// corrupted or pure noise, under both end-check settings and varying
// sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_json_structure_validator;

   localparam int DEPTH_LIMIT = jsv_pkg::MAX_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int PRINT_LIMIT = 100;
   localparam logic [jsv_pkg::TOKEN_W-1:0] TOK_RESERVED_LO = 4'd13;
   localparam logic [jsv_pkg::TOKEN_W-1:0] TOK_RESERVED_HI = 4'd15;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   jsv_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   jsv_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_wdata = 1'b0;

   jsv_pkg::req_type              token_backlog[$];
   jsv_pkg::rsp_type              expected_results[$];
   logic [jsv_pkg::TOKEN_W-1:0]   doc_toks[$];
   jsv_pkg::rsp_type              want_rsp;
   int                            tokens_queued = 0;
   int                            tokens_taken = 0;
   int                            mismatch_count = 0;
   int                            cycle_count = 0;
   int                            send_idle_pct = 0;
   int                            recv_idle_pct = 0;
   logic [jsv_pkg::LINE_W-1:0]    line_cursor = '0;

   // predictor state
   jsv_pkg::parse_state_type      ps;
   jsv_pkg::ret_type              ret_stack[DEPTH_LIMIT];
   int unsigned                   stk_cnt;
   bit                            await_eof;
   jsv_pkg::status_type           fin_status;
   logic [jsv_pkg::LINE_W-1:0]    err_line;
   bit                            end_check;

   json_structure_validator #(
      .MAX_DEPTH(DEPTH_LIMIT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic void restart_doc();
      ps = jsv_pkg::PS_VALUE;
      ret_stack[0] = jsv_pkg::RET_DONE;
      stk_cnt = 1;
      await_eof = 1'b0;
      fin_status = jsv_pkg::ST_BUSY;
      err_line = '0;
   endfunction

   function automatic void flag_error(logic [jsv_pkg::LINE_W-1:0] line);
      fin_status = jsv_pkg::ST_FAIL;
      err_line = line;
   endfunction

   function automatic bit is_scalar(logic [jsv_pkg::TOKEN_W-1:0] tc);
      return tc >= jsv_pkg::TOK_STRING && tc <= jsv_pkg::TOK_NUMBER;
   endfunction

   function automatic void pop_level();
      jsv_pkg::ret_type r;
      r = jsv_pkg::RET_DONE;
      if (stk_cnt > 0) begin
         r = ret_stack[stk_cnt - 1];
         stk_cnt--;
      end
      if (r == jsv_pkg::RET_DONE) begin
         ps = jsv_pkg::PS_VALUE;
         stk_cnt = 0;
         if (end_check) await_eof = 1'b1;
         else fin_status = jsv_pkg::ST_COMPLETE;
      end else begin
         ps = (r == jsv_pkg::RET_OBJ) ? jsv_pkg::PS_OBJ_NEXT : jsv_pkg::PS_ARR_NEXT;
      end
   endfunction

   function automatic void push_level(jsv_pkg::ret_type ret, jsv_pkg::parse_state_type nxt,
                                      logic [jsv_pkg::LINE_W-1:0] line);
      if (stk_cnt + 1 >= DEPTH_LIMIT) begin
         flag_error(line);
      end else begin
         ret_stack[stk_cnt] = ret;
         stk_cnt++;
         ps = nxt;
      end
   endfunction

   function automatic void advance_parse(logic [jsv_pkg::TOKEN_W-1:0] tc,
                                         logic [jsv_pkg::LINE_W-1:0] line);
      case (ps)
         jsv_pkg::PS_VALUE: begin
            if (tc == jsv_pkg::TOK_LBRACKET) ps = jsv_pkg::PS_ARR_VALUE;
            else if (tc == jsv_pkg::TOK_LBRACE) ps = jsv_pkg::PS_KEY_OR_CLOSE;
            else if (is_scalar(tc)) pop_level();
            else flag_error(line);
         end
         jsv_pkg::PS_KEY_OR_CLOSE: begin
            if (tc == jsv_pkg::TOK_RBRACE) pop_level();
            else if (tc == jsv_pkg::TOK_STRING) ps = jsv_pkg::PS_COLON;
            else flag_error(line);
         end
         jsv_pkg::PS_COLON: begin
            if (tc == jsv_pkg::TOK_COLON) ps = jsv_pkg::PS_OBJ_VALUE;
            else flag_error(line);
         end
         jsv_pkg::PS_OBJ_VALUE: begin
            if (is_scalar(tc)) ps = jsv_pkg::PS_OBJ_NEXT;
            else if (tc == jsv_pkg::TOK_LBRACKET)
               push_level(jsv_pkg::RET_OBJ, jsv_pkg::PS_ARR_VALUE, line);
            else if (tc == jsv_pkg::TOK_LBRACE)
               push_level(jsv_pkg::RET_OBJ, jsv_pkg::PS_KEY_OR_CLOSE, line);
            else flag_error(line);
         end
         jsv_pkg::PS_OBJ_NEXT: begin
            if (tc == jsv_pkg::TOK_COMMA) ps = jsv_pkg::PS_KEY_OR_CLOSE;
            else if (tc == jsv_pkg::TOK_RBRACE) pop_level();
            else flag_error(line);
         end
         jsv_pkg::PS_ARR_VALUE: begin
            if (tc == jsv_pkg::TOK_RBRACKET) pop_level();
            else if (is_scalar(tc)) ps = jsv_pkg::PS_ARR_NEXT;
            else if (tc == jsv_pkg::TOK_LBRACKET)
               push_level(jsv_pkg::RET_ARR, jsv_pkg::PS_ARR_VALUE, line);
            else if (tc == jsv_pkg::TOK_LBRACE)
               push_level(jsv_pkg::RET_ARR, jsv_pkg::PS_KEY_OR_CLOSE, line);
            else flag_error(line);
         end
         jsv_pkg::PS_ARR_NEXT: begin
            if (tc == jsv_pkg::TOK_RBRACKET) pop_level();
            else if (tc == jsv_pkg::TOK_COMMA) ps = jsv_pkg::PS_ARR_VALUE;
            else flag_error(line);
         end
         default: flag_error(line);
      endcase
   endfunction

   function automatic jsv_pkg::rsp_type next_parse_result(jsv_pkg::req_type t);
      jsv_pkg::rsp_type r;
      if (t.new_document) restart_doc();
      if (fin_status == jsv_pkg::ST_BUSY) begin
         if (await_eof) begin
            if (t.token_class == jsv_pkg::TOK_EOF) begin
               await_eof = 1'b0;
               fin_status = jsv_pkg::ST_COMPLETE;
            end else begin
               flag_error(t.token_line);
            end
         end else begin
            advance_parse(t.token_class, t.token_line);
         end
      end
      r.parse_status = fin_status;
      r.nesting_depth = (ps == jsv_pkg::PS_VALUE) ? '0 : jsv_pkg::DEPTH_W'(stk_cnt);
      r.error_line = (fin_status == jsv_pkg::ST_FAIL) ? err_line : '0;
      return r;
   endfunction

   function automatic logic [jsv_pkg::LINE_W-1:0] pick_line();
      if ($urandom_range(0, 9) == 0) line_cursor = jsv_pkg::LINE_W'($urandom);
      else line_cursor = line_cursor + jsv_pkg::LINE_W'($urandom_range(0, 2));
      return line_cursor;
   endfunction

   function automatic void add_token(bit fresh, logic [jsv_pkg::TOKEN_W-1:0] tc,
                                     logic [jsv_pkg::LINE_W-1:0] line);
      jsv_pkg::req_type t;
      t.new_document = fresh;
      t.token_class = tc;
      t.token_line = line;
      token_backlog.push_back(t);
      tokens_queued++;
   endfunction

   // first token takes first_fresh, later ones restart with restart_pct odds
   function automatic void send_doc(bit first_fresh, int restart_pct);
      for (int i = 0; i < doc_toks.size(); i++)
         add_token(i == 0 ? first_fresh : ($urandom_range(0, 99) < restart_pct),
                   doc_toks[i], pick_line());
   endfunction

   function automatic void gen_value(int levels);
      int kind;
      int count;
      kind = (levels == 0) ? 0 : $urandom_range(0, 9);
      count = $urandom_range(0, 3);
      if (kind < 3) begin
         doc_toks.push_back(jsv_pkg::TOKEN_W'($urandom_range(jsv_pkg::TOK_STRING,
                                                             jsv_pkg::TOK_NUMBER)));
      end else if (kind < 6) begin
         doc_toks.push_back(jsv_pkg::TOK_LBRACKET);
         for (int i = 0; i < count; i++) begin
            if (i != 0) doc_toks.push_back(jsv_pkg::TOK_COMMA);
            gen_value(levels - 1);
         end
         doc_toks.push_back(jsv_pkg::TOK_RBRACKET);
      end else begin
         doc_toks.push_back(jsv_pkg::TOK_LBRACE);
         for (int i = 0; i < count; i++) begin
            if (i != 0) doc_toks.push_back(jsv_pkg::TOK_COMMA);
            doc_toks.push_back(jsv_pkg::TOK_STRING);
            doc_toks.push_back(jsv_pkg::TOK_COLON);
            gen_value(levels - 1);
         end
         doc_toks.push_back(jsv_pkg::TOK_RBRACE);
      end
   endfunction

   // opens levels containers; then either one push too many or unwind
   function automatic void add_deep_doc(int levels, bit overflow);
      bit is_obj[DEPTH_LIMIT];
      for (int i = 0; i < levels; i++) begin
         is_obj[i] = (i % 3 == 1) && (i < 30);
         if (is_obj[i]) begin
            add_token(1'b0, jsv_pkg::TOK_LBRACE, pick_line());
            add_token(1'b0, jsv_pkg::TOK_STRING, pick_line());
            add_token(1'b0, jsv_pkg::TOK_COLON, pick_line());
         end else begin
            add_token(i == 0, jsv_pkg::TOK_LBRACKET, pick_line());
         end
      end
      if (overflow) begin
         add_token(1'b0, jsv_pkg::TOK_LBRACE, pick_line());
      end else begin
         add_token(1'b0, jsv_pkg::TOK_NUMBER, pick_line());
         for (int i = levels - 1; i >= 0; i--)
            add_token(1'b0, is_obj[i] ? jsv_pkg::TOK_RBRACE : jsv_pkg::TOK_RBRACKET,
                      pick_line());
      end
   endfunction

   function automatic void add_random_docs(int target);
      int made;
      int roll;
      int cut;
      int pos;
      made = 0;
      while (made < target) begin
         doc_toks.delete();
         roll = $urandom_range(0, 99);
         if (roll < 85) begin
            gen_value($urandom_range(0, 4));
            if (end_check || $urandom_range(0, 1) == 1) doc_toks.push_back(jsv_pkg::TOK_EOF);
            if (roll >= 70) begin
               cut = $urandom_range(1, doc_toks.size());
               while (doc_toks.size() > cut) void'(doc_toks.pop_back());
            end
            if ($urandom_range(0, 3) == 0) begin
               pos = $urandom_range(0, doc_toks.size() - 1);
               doc_toks[pos] = jsv_pkg::TOKEN_W'($urandom_range(0, 15));
            end
            made += doc_toks.size();
            send_doc(1'b1, 2);
         end else begin
            repeat ($urandom_range(1, 6))
               doc_toks.push_back(jsv_pkg::TOKEN_W'($urandom_range(0, 15)));
            made += doc_toks.size();
            send_doc(1'($urandom_range(0, 1)), 20);
         end
         if ($urandom_range(0, 4) == 0)
            add_token(1'b0, jsv_pkg::TOKEN_W'($urandom_range(0, 15)), pick_line());
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   task automatic wait_drained();
      while (tokens_taken != tokens_queued || expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_end_check(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      end_check = value;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // token driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(next_parse_result(req_data));
            tokens_taken++;
         end
         if (!req_valid || req_ready) begin
            if (token_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data  <= token_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result transaction with no token outstanding");
            end else begin
               want_rsp = expected_results.pop_front();
               if (rsp_data.parse_status !== want_rsp.parse_status)
                  report_mismatch($sformatf("parse_status got %0d want %0d",
                                            rsp_data.parse_status, want_rsp.parse_status));
               if (rsp_data.nesting_depth !== want_rsp.nesting_depth)
                  report_mismatch($sformatf("nesting_depth got %0d want %0d",
                                            rsp_data.nesting_depth, want_rsp.nesting_depth));
               if (rsp_data.error_line !== want_rsp.error_line)
                  report_mismatch($sformatf("error_line got %0d want %0d",
                                            rsp_data.error_line, want_rsp.error_line));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      end_check = 1'b0;
      restart_doc();
      send_idle_pct = 16;
      recv_idle_pct = 57;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_end_check(1'b0);

      // document straight out of reset, then tokens after completion
      add_token(1'b0, jsv_pkg::TOK_LBRACKET, pick_line());
      add_token(1'b0, jsv_pkg::TOK_RBRACKET, pick_line());
      add_token(1'b0, jsv_pkg::TOK_NUMBER, pick_line());
      doc_toks = '{jsv_pkg::TOK_NUMBER};
      send_doc(1'b1, 0);
      doc_toks = '{jsv_pkg::TOK_LBRACE, jsv_pkg::TOK_RBRACE};
      send_doc(1'b1, 0);
      doc_toks = '{jsv_pkg::TOK_LBRACE, jsv_pkg::TOK_STRING, jsv_pkg::TOK_COLON,
                   jsv_pkg::TOK_TRUE, jsv_pkg::TOK_COMMA, jsv_pkg::TOK_STRING,
                   jsv_pkg::TOK_COLON, jsv_pkg::TOK_LBRACKET, jsv_pkg::TOK_FALSE,
                   jsv_pkg::TOK_COMMA, jsv_pkg::TOK_NULL, jsv_pkg::TOK_RBRACKET,
                   jsv_pkg::TOK_RBRACE};
      send_doc(1'b1, 0);
      add_token(1'b1, jsv_pkg::TOK_LBRACKET, pick_line());
      add_token(1'b0, jsv_pkg::TOK_EOF, '1);
      add_token(1'b0, jsv_pkg::TOK_RBRACKET, pick_line());
      add_token(1'b1, jsv_pkg::TOK_OTHER, '0);
      add_token(1'b1, TOK_RESERVED_LO, pick_line());
      add_token(1'b1, TOK_RESERVED_HI, '1);
      add_token(1'b1, jsv_pkg::TOK_COLON, pick_line());
      add_token(1'b1, jsv_pkg::TOK_COMMA, pick_line());
      add_token(1'b1, jsv_pkg::TOK_RBRACE, pick_line());
      add_deep_doc(DEPTH_LIMIT - 1, 1'b1);
      add_deep_doc(60, 1'b0);
      // end check is sampled when the outermost value closes
      add_token(1'b1, jsv_pkg::TOK_LBRACKET, pick_line());
      wait_drained();
      write_end_check(1'b1);
      add_token(1'b0, jsv_pkg::TOK_RBRACKET, pick_line());
      add_token(1'b0, jsv_pkg::TOK_EOF, pick_line());
      doc_toks = '{jsv_pkg::TOK_LBRACKET, jsv_pkg::TOK_RBRACKET, jsv_pkg::TOK_EOF};
      send_doc(1'b1, 0);
      doc_toks = '{jsv_pkg::TOK_STRING, jsv_pkg::TOK_NUMBER};
      send_doc(1'b1, 0);
      doc_toks = '{jsv_pkg::TOK_LBRACKET, jsv_pkg::TOK_LBRACKET};
      send_doc(1'b1, 0);
      doc_toks = '{jsv_pkg::TOK_LBRACE, jsv_pkg::TOK_RBRACE, jsv_pkg::TOK_EOF};
      send_doc(1'b1, 0);
      add_token(1'b1, jsv_pkg::TOK_LBRACE, pick_line());
      wait_drained();
      write_end_check(1'b0);
      add_token(1'b0, jsv_pkg::TOK_RBRACE, pick_line());
      add_token(1'b0, jsv_pkg::TOK_EOF, pick_line());
      wait_drained();

      write_end_check(1'b1);
      add_random_docs(60);
      wait_drained();
      add_random_docs(60);
      wait_drained();

      send_idle_pct = 57;
      recv_idle_pct = 16;
      write_end_check(1'b0);
      add_random_docs(120);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_end_check(1'b1);
      add_random_docs(60);
      wait_drained();
      write_end_check(1'b0);
      add_random_docs(60);
      wait_drained();

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
